[rtl/remote_scancode_to_keycode_translator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the remote scancode to keycode translator
// Simulation builds check the properties; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef REMOTE_SCANCODE_TO_KEYCODE_TRANSLATOR_ASSERT_SVH
`define REMOTE_SCANCODE_TO_KEYCODE_TRANSLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, off during reset
`define RSK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsk: same-cycle check failed");

// next-cycle implication, off during reset
`define RSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsk: next-cycle check failed");

`else

`define RSK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RSK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/rsk_pkg.sv]
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types, codes and the scancode map of the keycode translator.
// ----------------------------------------------------------------------------
package rsk_pkg;

  // item kinds
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;

  // scancodes with their own handling
  localparam logic [7:0] SC_TAB     = 8'd15;
  localparam logic [7:0] SC_CTRL    = 8'd29;
  localparam logic [7:0] SC_NUMLOCK = 8'd69;
  localparam logic [7:0] SC_CAPS    = 8'd58;
  localparam logic [7:0] SC_SCROLL  = 8'd70;

  // keycodes
  localparam logic [8:0] KEY_OFFSET  = 9'd8;
  localparam logic [8:0] KC_TAB      = 9'd23;
  localparam logic [8:0] KC_CTRL_L   = 9'd37;
  localparam logic [8:0] KC_CTRL_R   = 9'd109;
  localparam logic [8:0] KC_PAUSE    = 9'd110;
  localparam logic [8:0] KC_NUMLOCK  = 9'd77;
  localparam logic [8:0] KC_CAPS     = 9'd66;
  localparam logic [8:0] KC_SCROLL   = 9'd78;

  localparam int MAX_EVENTS  = 7;
  localparam int CNT_W       = $clog2(MAX_EVENTS + 1);
  localparam int IDX_W       = $clog2(MAX_EVENTS);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] scancode;
    logic       extended;
    logic       special;
    logic [2:0] lock_request;
    logic       host_caps_on;
    logic       host_num_on;
    logic       host_scroll_on;
  } key_item_t;

  typedef struct packed {
    logic [8:0] keycode;
    logic       pressed;
    logic       last;
  } event_item_t;

  typedef struct packed {
    logic [8:0] keycode;
    logic       pressed;
  } key_event_t;

  // all events caused by one item
  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    key_event_t [MAX_EVENTS-1:0]     ev;
  } plan_t;

  typedef struct packed {
    logic       single;
    logic [8:0] code;
  } key_map_t;

  // Map an ordinary key: single-event keys or release-then-press keys.
  function automatic key_map_t key_map(input logic [7:0] sc, input logic ext);
    key_map_t m;
    m.single = 1'b0;
    m.code   = {1'b0, sc} + KEY_OFFSET;
    case (sc)
      8'd58, 8'd42, 8'd54, 8'd70: m.single = 1'b1;
      8'd56: begin m.single = 1'b1; m.code = ext ? 9'd113 : 9'd64; end
      8'd91: begin m.single = 1'b1; m.code = 9'd115; end
      8'd92: begin m.single = 1'b1; m.code = 9'd116; end
      8'd93: begin m.single = 1'b1; m.code = 9'd117; end
      8'd28: m.code = ext ? 9'd108 : 9'd36;
      8'd53: m.code = ext ? 9'd112 : 9'd61;
      8'd55: m.code = ext ? 9'd111 : 9'd63;
      8'd71: m.code = ext ? 9'd97  : 9'd79;
      8'd72: m.code = ext ? 9'd98  : 9'd80;
      8'd73: m.code = ext ? 9'd99  : 9'd81;
      8'd75: m.code = ext ? 9'd100 : 9'd83;
      8'd77: m.code = ext ? 9'd102 : 9'd85;
      8'd79: m.code = ext ? 9'd103 : 9'd87;
      8'd80: m.code = ext ? 9'd104 : 9'd88;
      8'd81: m.code = ext ? 9'd105 : 9'd89;
      8'd82: m.code = ext ? 9'd106 : 9'd90;
      8'd83: m.code = ext ? 9'd107 : 9'd91;
      default: m.single = 1'b0;
    endcase
    return m;
  endfunction

endpackage

[rtl/remote_scancode_to_keycode_translator.sv]
// ----------------------------------------------------------------------------
// remote_scancode_to_keycode_translator
// Turns remote key and lock-sync items into X keycode press/release events.
// ----------------------------------------------------------------------------
//   channel  valid        stall        payload
//   key      key_valid    key_stall    key_item   (kind, scancode, flags, locks)
//   event    event_valid  event_stall  event_item (keycode, pressed, last)
//
// An item is taken while the list queue has room; it is written to the queue
// memory and its events are loaded from there into the output register. Events
// leave at one per cycle while the event side does not stall, up to 7 per item
// (a lock sync that flips all three locks); an item with no events is not queued.
// Reset clears key state, the queue and the output valid.
// Either side may stall; the queue of QueueDepth lists keeps them apart.
// ----------------------------------------------------------------------------
module remote_scancode_to_keycode_translator #(
  parameter int QueueDepth = rsk_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 key_valid,
  output logic                 key_stall,
  input  rsk_pkg::key_item_t   key_item,
  output logic                 event_valid,
  input  logic                 event_stall,
  output rsk_pkg::event_item_t event_item
);
  import rsk_pkg::*;

  logic  push;
  logic  pop;
  logic  q_valid;
  logic  q_full;
  plan_t push_plan;
  plan_t head;

  // classify items and track key state
  rsk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_item  (key_item),
    .q_full    (q_full),
    .push      (push),
    .plan      (push_plan)
  );

  // hold event lists between the two sides
  rsk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  // emit events one at a time
  rsk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item)
  );

endmodule

[rtl/rsk_front.sv]
// ----------------------------------------------------------------------------
// rsk_front
// Accepts key and sync items, tracks tab, control and pause state, and
// turns each item into its list of keycode events.
// ----------------------------------------------------------------------------
module rsk_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_stall,
  input  rsk_pkg::key_item_t key_item,
  input  logic              q_full,
  output logic              push,
  output rsk_pkg::plan_t    plan
);
  import rsk_pkg::*;

  logic       tab_held, tab_held_next;
  logic [6:0] ctrl_held_code, ctrl_held_code_next;
  logic       pause_pending, pause_pending_next;

  logic       accept;
  logic       down;
  key_map_t   km;
  logic [8:0] num_code;
  logic [8:0] ctrl_code;
  logic       caps_diff, num_diff, scroll_diff;
  logic [2:0] pos;

  assign key_stall = q_full;
  assign accept    = key_valid && !key_stall;
  assign push      = accept && (plan.cnt != '0);

  // classify the item and build its events
  always_comb begin
    down                = (key_item.kind == KIND_DOWN);
    km                  = key_map(key_item.scancode, key_item.extended);
    num_code            = (pause_pending || ctrl_held_code != '0) ? KC_PAUSE : KC_NUMLOCK;
    ctrl_code           = key_item.extended ? KC_CTRL_R : KC_CTRL_L;
    caps_diff           = key_item.host_caps_on   != key_item.lock_request[2];
    num_diff            = key_item.host_num_on    != key_item.lock_request[1];
    scroll_diff         = key_item.host_scroll_on != key_item.lock_request[0];
    pos                 = '0;
    plan                = '0;
    tab_held_next       = tab_held;
    ctrl_held_code_next = ctrl_held_code;
    pause_pending_next  = pause_pending;
    case (key_item.kind)
      KIND_DOWN, KIND_UP: begin
        case (key_item.scancode)
          SC_TAB: begin
            tab_held_next = down;
            if (!down && !tab_held) begin
              // stray tab release drops a held control
              if (ctrl_held_code != '0) begin
                plan.cnt            = CNT_W'(1);
                plan.ev[0]          = '{keycode: {2'b00, ctrl_held_code}, pressed: 1'b0};
                ctrl_held_code_next = '0;
              end
            end else begin
              plan.ev[0] = '{keycode: KC_TAB, pressed: 1'b0};
              plan.ev[1] = '{keycode: KC_TAB, pressed: 1'b1};
              plan.cnt   = down ? CNT_W'(2) : CNT_W'(1);
            end
          end
          SC_CTRL: begin
            if (key_item.special) begin
              if (down) begin
                pause_pending_next = 1'b1;
              end
            end else begin
              ctrl_held_code_next = down ? ctrl_code[6:0] : 7'd0;
              plan.cnt            = CNT_W'(1);
              plan.ev[0]          = '{keycode: ctrl_code, pressed: down};
            end
          end
          SC_NUMLOCK: begin
            if (!down && pause_pending) begin
              pause_pending_next = 1'b0;
            end
            plan.ev[0] = '{keycode: num_code, pressed: 1'b0};
            plan.ev[1] = '{keycode: num_code, pressed: 1'b1};
            plan.cnt   = down ? CNT_W'(2) : CNT_W'(1);
          end
          default: begin
            if (km.single) begin
              plan.ev[0] = '{keycode: km.code, pressed: down};
              plan.cnt   = CNT_W'(1);
            end else begin
              plan.ev[0] = '{keycode: km.code, pressed: 1'b0};
              plan.ev[1] = '{keycode: km.code, pressed: 1'b1};
              plan.cnt   = down ? CNT_W'(2) : CNT_W'(1);
            end
          end
        endcase
      end
      KIND_SYNC: begin
        // caps, then num, then scroll, packed one after another
        if (caps_diff) begin
          plan.ev[pos]        = '{keycode: KC_CAPS, pressed: 1'b1};
          plan.ev[pos + 3'd1] = '{keycode: KC_CAPS, pressed: 1'b0};
          pos                 = pos + 3'd2;
        end
        if (num_diff) begin
          plan.ev[pos]        = '{keycode: num_code, pressed: 1'b0};
          plan.ev[pos + 3'd1] = '{keycode: num_code, pressed: 1'b1};
          plan.ev[pos + 3'd2] = '{keycode: num_code, pressed: 1'b0};
          pos                 = pos + 3'd3;
          pause_pending_next  = 1'b0;
        end
        if (scroll_diff) begin
          plan.ev[pos]        = '{keycode: KC_SCROLL, pressed: 1'b1};
          plan.ev[pos + 3'd1] = '{keycode: KC_SCROLL, pressed: 1'b0};
          pos                 = pos + 3'd2;
        end
        plan.cnt = CNT_W'(pos);
      end
      default: plan.cnt = '0;
    endcase
  end

  // update key state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_held       <= 1'b0;
      ctrl_held_code <= '0;
      pause_pending  <= 1'b0;
    end else if (accept) begin
      tab_held       <= tab_held_next;
      ctrl_held_code <= ctrl_held_code_next;
      pause_pending  <= pause_pending_next;
    end
  end

endmodule

[rtl/rsk_queue.sv]
// ----------------------------------------------------------------------------
// rsk_queue
// Short queue of event lists between the front and the back.
// ----------------------------------------------------------------------------
module rsk_queue #(
  parameter int Depth = rsk_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsk_pkg::plan_t push_plan,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output rsk_pkg::plan_t head
);
  import rsk_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  plan_t            mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CntW'(Depth));
  assign head    = mem[rd_ptr];

  // store pushed lists
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_plan;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/rsk_back.sv]
// ----------------------------------------------------------------------------
// rsk_back
// Walks each list to the output register, one event per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "remote_scancode_to_keycode_translator_assert.svh"

module rsk_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  rsk_pkg::plan_t       head,
  output logic                 pop,
  output logic                 event_valid,
  input  logic                 event_stall,
  output rsk_pkg::event_item_t event_item
);
  import rsk_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             is_last;

  assign load    = !event_valid || !event_stall;
  assign is_last = (idx == IDX_W'(head.cnt - CNT_W'(1)));
  assign pop     = load && q_valid && is_last;

  // hold a stalled event, otherwise load the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      event_valid <= q_valid;
      if (q_valid) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      event_item.keycode <= head.ev[idx].keycode;
      event_item.pressed <= head.ev[idx].pressed;
      event_item.last    <= is_last;
    end
  end

  `RSK_ASSERT_IMPLY(a_pop_has_head, clk, rst, pop, q_valid)
  `RSK_ASSERT_IMPLY(a_idx_in_list, clk, rst, q_valid, (idx < head.cnt))
  `RSK_ASSERT_NEXT(a_idx_wraps, clk, rst, pop, (idx == '0))
  `RSK_ASSERT_NEXT(a_last_on_pop, clk, rst, pop, (event_valid && event_item.last))

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: keycode translator testbench
// Drives key, lock-sync and unused-kind items into the translator and checks
// every press/release event against an in-bench translation of the item with
// its own copy of tab, control and pause state. Both sides idle at random,
// and the event side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsk_pkg::*;

  // kind value that the block must ignore
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS  = 145;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  // no-progress limit: several long hold-offs back to back
  localparam int STUCK_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;

  // --------------------------------------------------------------------------
  // expected-event store with its own translation state
  // --------------------------------------------------------------------------
  class keycode_scoreboard;
    bit          tab_is_held;
    logic [8:0]  ctrl_code;
    bit          pause_armed;
    key_event_t  batch[$];
    event_item_t expected_q[$];
    int          mismatches;
    int          events_seen;
    int          items_seen;
    int          syncs_seen;
    int          spares_seen;

    function void emit(logic [8:0] code, bit press);
      key_event_t e;
      if (batch.size() < MAX_EVENTS) begin
        e.keycode = code;
        e.pressed = press;
        batch.push_back(e);
      end
    endfunction

    // release first, then press on a down
    function void emit_repeat(logic [8:0] code, bit down);
      emit(code, 1'b0);
      if (down) emit(code, 1'b1);
    endfunction

    function void translate_key(bit down, logic [7:0] sc, bit ext, bit spe);
      logic [8:0] code;
      bit         lone;
      case (sc)
        SC_TAB: begin
          // stray tab release drops a held control
          if (!down && !tab_is_held) begin
            if (ctrl_code != '0) begin
              emit(ctrl_code, 1'b0);
              ctrl_code = '0;
            end
          end else begin
            emit_repeat(KC_TAB, down);
          end
          tab_is_held = down;
        end
        SC_CTRL: begin
          if (spe) begin
            if (down) pause_armed = 1'b1;
          end else begin
            code = ext ? KC_CTRL_R : KC_CTRL_L;
            ctrl_code = down ? code : '0;
            emit(code, down);
          end
        end
        SC_NUMLOCK: begin
          if (pause_armed) begin
            code = KC_PAUSE;
            if (!down) pause_armed = 1'b0;
          end else begin
            code = (ctrl_code != '0) ? KC_PAUSE : KC_NUMLOCK;
          end
          emit_repeat(code, down);
        end
        default: begin
          code = {1'b0, sc} + KEY_OFFSET;
          lone = 1'b0;
          case (sc)
            SC_CAPS, SC_SCROLL, 8'd42, 8'd54: lone = 1'b1;
            8'd56: begin lone = 1'b1; code = ext ? 9'd113 : 9'd64; end
            8'd91: begin lone = 1'b1; code = 9'd115; end
            8'd92: begin lone = 1'b1; code = 9'd116; end
            8'd93: begin lone = 1'b1; code = 9'd117; end
            // keypad versus navigation pairs
            8'd28: code = ext ? 9'd108 : 9'd36;
            8'd53: code = ext ? 9'd112 : 9'd61;
            8'd55: code = ext ? 9'd111 : 9'd63;
            8'd71: code = ext ? 9'd97  : 9'd79;
            8'd72: code = ext ? 9'd98  : 9'd80;
            8'd73: code = ext ? 9'd99  : 9'd81;
            8'd75: code = ext ? 9'd100 : 9'd83;
            8'd77: code = ext ? 9'd102 : 9'd85;
            8'd79: code = ext ? 9'd103 : 9'd87;
            8'd80: code = ext ? 9'd104 : 9'd88;
            8'd81: code = ext ? 9'd105 : 9'd89;
            8'd82: code = ext ? 9'd106 : 9'd90;
            8'd83: code = ext ? 9'd107 : 9'd91;
            default: ;
          endcase
          if (lone) emit(code, down);
          else emit_repeat(code, down);
        end
      endcase
    endfunction

    function void toggle_lock(logic [7:0] sc);
      translate_key(1'b1, sc, 1'b0, 1'b0);
      translate_key(1'b0, sc, 1'b0, 1'b0);
    endfunction

    // note an accepted key item and queue the events it causes
    function void note_item(key_item_t it);
      event_item_t ev;
      batch.delete();
      items_seen++;
      case (it.kind)
        KIND_DOWN: translate_key(1'b1, it.scancode, it.extended, it.special);
        KIND_UP:   translate_key(1'b0, it.scancode, it.extended, it.special);
        KIND_SYNC: begin
          syncs_seen++;
          if (it.host_caps_on != it.lock_request[2]) toggle_lock(SC_CAPS);
          if (it.host_num_on != it.lock_request[1]) toggle_lock(SC_NUMLOCK);
          if (it.host_scroll_on != it.lock_request[0]) toggle_lock(SC_SCROLL);
        end
        default: spares_seen++;
      endcase
      foreach (batch[i]) begin
        ev.keycode = batch[i].keycode;
        ev.pressed = batch[i].pressed;
        ev.last    = (i == batch.size() - 1);
        expected_q.push_back(ev);
      end
    endfunction

    // check one accepted event against the oldest expectation
    function void check_event(event_item_t got);
      event_item_t want;
      events_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected event keycode=%0d pressed=%0d last=%0d",
                   $realtime, got.keycode, got.pressed, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.keycode !== want.keycode || got.pressed !== want.pressed ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: event mismatch: keycode %0d/%0d pressed %0d/%0d last %0d/%0d",
                   $realtime, want.keycode, got.keycode, want.pressed, got.pressed,
                   want.last, got.last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        key_valid;
  logic        key_stall;
  key_item_t   key_item;
  logic        event_valid;
  logic        event_stall;
  event_item_t event_item;

  keycode_scoreboard sb = new();

  int tx_idle_pct = 23;
  int rx_idle_pct = 76;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int stuck_cycles = 0;

  logic [7:0] hot_codes [23] = '{8'd15, 8'd29, 8'd69, 8'd58, 8'd70, 8'd42, 8'd54,
                                 8'd56, 8'd91, 8'd92, 8'd93, 8'd28, 8'd53, 8'd55,
                                 8'd71, 8'd72, 8'd73, 8'd75, 8'd77, 8'd79, 8'd80,
                                 8'd81, 8'd83};

  remote_scancode_to_keycode_translator u_top (
    .clk         (clk),
    .rst         (rst),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .key_item    (key_item),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_item  (event_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // monitor both channels
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && key_valid && !key_stall) sb.note_item(key_item);
    if (!rst && event_valid && !event_stall) sb.check_event(event_item);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (key_valid && !key_stall) || (event_valid && !event_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // event side: random stall, or one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    event_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        event_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        event_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // key side
  // --------------------------------------------------------------------------
  // offer one item, idling cycle by cycle at random; return once it is taken
  task automatic send_item(key_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key_item  <= it;
    do @(posedge clk); while (key_stall);
    items_sent++;
  endtask

  // key item with the given fields and random filler elsewhere
  function automatic key_item_t make_key(logic [1:0] kind, logic [7:0] sc, bit ext,
                                         bit spe);
    key_item_t it;
    it = $bits(key_item_t)'($urandom);
    it.kind     = kind;
    it.scancode = sc;
    it.extended = ext;
    it.special  = spe;
    return it;
  endfunction

  function automatic key_item_t make_sync(logic [2:0] req, bit caps, bit num,
                                          bit scroll);
    key_item_t it;
    it = make_key(KIND_SYNC, 8'($urandom), 1'b0, 1'b0);
    it.lock_request   = req;
    it.host_caps_on   = caps;
    it.host_num_on    = num;
    it.host_scroll_on = scroll;
    return it;
  endfunction

  // loose item: any kind, often an interesting scancode
  function automatic key_item_t random_item();
    key_item_t it;
    int        pick;
    it = $bits(key_item_t)'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) it.kind = KIND_DOWN;
    else if (pick < 85) it.kind = KIND_UP;
    else if (pick < 97) it.kind = KIND_SYNC;
    else it.kind = KIND_SPARE;
    if ($urandom_range(99) < 55) it.scancode = hot_codes[$urandom_range(22)];
    return it;
  endfunction

  // well-formed key sequence with random content
  task automatic run_sequence();
    logic [7:0] sc;
    bit         ext;
    sc  = hot_codes[$urandom_range(22)];
    ext = ($urandom_range(1) == 1);
    case ($urandom_range(4))
      0: begin
        // special control prefix turns NumLock into Pause
        send_item(make_key(KIND_DOWN, SC_CTRL, ext, 1'b1));
        send_item(make_key(KIND_DOWN, SC_NUMLOCK, ext, $urandom_range(1) == 1));
        if ($urandom_range(1) == 1)
          send_item(make_key(KIND_UP, SC_NUMLOCK, ext, 1'b0));
        send_item(make_key(KIND_UP, SC_CTRL, ext, 1'b1));
      end
      1: begin
        // control chord, sometimes with a stray tab release
        send_item(make_key(KIND_DOWN, SC_CTRL, ext, 1'b0));
        if ($urandom_range(1) == 1)
          send_item(make_key(KIND_DOWN, SC_TAB, ext, 1'b0));
        send_item(make_key(KIND_UP, SC_TAB, ext, 1'b0));
        if ($urandom_range(1) == 1)
          send_item(make_key(KIND_DOWN, sc, ext, 1'b0));
        send_item(make_key(KIND_UP, SC_CTRL, ext, 1'b0));
      end
      2: begin
        // tap with optional autorepeat
        send_item(make_key(KIND_DOWN, sc, ext, 1'b0));
        if ($urandom_range(1) == 1)
          send_item(make_key(KIND_DOWN, sc, ext, 1'b0));
        send_item(make_key(KIND_UP, sc, ext, 1'b0));
      end
      3: begin
        send_item(make_sync(3'($urandom), $urandom_range(1) == 1,
                            $urandom_range(1) == 1, $urandom_range(1) == 1));
      end
      default: begin
        // held control, then NumLock and a lock sync
        send_item(make_key(KIND_DOWN, SC_CTRL, ext, 1'b0));
        send_item(make_key(KIND_DOWN, SC_NUMLOCK, 1'b0, 1'b0));
        send_item(make_key(KIND_UP, SC_NUMLOCK, 1'b0, 1'b0));
        send_item(make_sync(3'($urandom), 1'b0, $urandom_range(1) == 1, 1'b0));
        send_item(make_key(KIND_UP, SC_CTRL, ext, 1'b0));
      end
    endcase
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 35) send_item(random_item());
      else run_sequence();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    key_valid = 1'b0;
    key_item  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, mapping groups, special cases
    send_item(make_key(KIND_DOWN, 8'd0, 1'b0, 1'b0));
    send_item(make_key(KIND_UP, 8'd255, 1'b1, 1'b1));
    send_item(make_key(KIND_DOWN, SC_CAPS, 1'b1, 1'b1));
    send_item(make_key(KIND_DOWN, 8'd56, 1'b1, 1'b0));
    send_item(make_key(KIND_UP, 8'd56, 1'b0, 1'b0));
    send_item(make_key(KIND_DOWN, 8'd91, 1'b0, 1'b0));
    send_item(make_key(KIND_DOWN, SC_CTRL, 1'b1, 1'b0));
    send_item(make_key(KIND_DOWN, SC_NUMLOCK, 1'b0, 1'b0));
    send_item(make_key(KIND_UP, SC_TAB, 1'b0, 1'b0));
    send_item(make_key(KIND_UP, SC_TAB, 1'b0, 1'b0));
    send_item(make_key(KIND_DOWN, SC_TAB, 1'b0, 1'b0));
    send_item(make_key(KIND_UP, SC_TAB, 1'b0, 1'b0));
    send_item(make_key(KIND_DOWN, SC_CTRL, 1'b0, 1'b1));
    send_item(make_key(KIND_UP, SC_CTRL, 1'b0, 1'b1));
    send_item(make_key(KIND_DOWN, SC_NUMLOCK, 1'b0, 1'b0));
    send_item(make_key(KIND_UP, SC_NUMLOCK, 1'b0, 1'b0));
    send_item(make_key(KIND_DOWN, SC_NUMLOCK, 1'b0, 1'b0));
    send_item(make_key(KIND_DOWN, 8'd28, 1'b1, 1'b0));
    send_item(make_key(KIND_SPARE, SC_TAB, 1'b1, 1'b1));
    send_item(make_sync(3'd7, 1'b0, 1'b0, 1'b0));
    send_item(make_sync(3'd0, 1'b1, 1'b1, 1'b1));
    send_item(make_sync(3'd5, 1'b1, 1'b0, 1'b1));
    send_item(make_key(KIND_DOWN, SC_CTRL, 1'b0, 1'b0));
    send_item(make_sync(3'd2, 1'b0, 1'b0, 1'b0));
    send_item(make_key(KIND_UP, SC_CTRL, 1'b0, 1'b0));

    // random, key side idles less than the event side
    run_random(PHASE_ITEMS);

    // swap the idling
    tx_idle_pct = 76;
    rx_idle_pct = 23;
    run_random(PHASE_ITEMS);

    // no idling; one long hold-off on the event side fills the block
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    run_random(PHASE_ITEMS);
    key_valid <= 1'b0;

    // drain, then watch for stray events
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.mismatches++;

    $display("covered %0d key items (%0d lock syncs, %0d unused kinds), %0d events checked",
             sb.items_seen, sb.syncs_seen, sb.spares_seen, sb.events_seen);
    $display("event mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
